/* sv/rdsm_pkg.sv */
// ----------------------------------------------------------------------------
// rdsm_pkg
// Shared constants and types for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package rdsm_pkg;

    // pattern character codes
    localparam logic [7:0] CH_ANY  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    // register file layout
    localparam int PAT_CHARS = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int LEN_W     = 5;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;

    // per-item control shared by every cell
    typedef struct packed {
        logic advance;   // item accepted this cycle
        logic use_base;  // start from the base row
        logic has_char;  // text character present
    } cell_ctrl_t;

endpackage

/* sv/rdsm_cfg.sv */
// ----------------------------------------------------------------------------
// rdsm_cfg
// Configuration registers on an APB-style port, plus the registered base row
// (the row for an empty text) derived from the pattern as it is written.
// ----------------------------------------------------------------------------
module rdsm_cfg #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rdsm_pkg::PADDR_W-1:0]           paddr,
    input  logic [rdsm_pkg::PDATA_W-1:0]           pwdata,
    output logic [rdsm_pkg::PDATA_W-1:0]           prdata,
    output logic [rdsm_pkg::LEN_W-1:0]             pattern_length,
    output logic [8*rdsm_pkg::PAT_CHARS-1:0]       pattern_chars,
    output logic [PATTERN_MAX:0]                   base_row
);
    import rdsm_pkg::*;

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [PDATA_W-1:0]     low_reg;
    logic [PDATA_W-1:0]     low_next;
    logic [PDATA_W-1:0]     high_reg;
    logic [PDATA_W-1:0]     high_next;
    logic [PATTERN_MAX:0]   base_reg;
    logic [PATTERN_MAX:0]   base_next;
    logic [8*PAT_CHARS-1:0] chars_next;
    logic                   wr_en;
    logic [1:0]             reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    // register write decode
    always_comb
    begin
        len_next  = len_reg;
        low_next  = low_reg;
        high_next = high_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LENGTH: len_next  = pwdata[LEN_W-1:0];
                REG_LOW:    low_next  = pwdata;
                REG_HIGH:   high_next = pwdata;
                default:    len_next  = len_reg;
            endcase
        end
    end

    // base row of the pattern being written: x* pairs may match nothing
    assign chars_next = {high_next, low_next};

    always_comb
    begin
        base_next    = '0;
        base_next[0] = 1'b1;
        for (int j = 2; j <= PATTERN_MAX; j++)
        begin
            base_next[j] = (chars_next[8*(j-1) +: 8] == CH_STAR) & base_next[j-2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
            base_reg <= {{PATTERN_MAX{1'b0}}, 1'b1};
        end
        else
        begin
            len_reg  <= len_next;
            low_reg  <= low_next;
            high_reg <= high_next;
            base_reg <= base_next;
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_LENGTH: prdata = {{(PDATA_W-LEN_W){1'b0}}, len_reg};
            REG_LOW:    prdata = low_reg;
            REG_HIGH:   prdata = high_reg;
            default:    prdata = '0;
        endcase
    end

    assign pattern_length = len_reg;
    assign pattern_chars  = {high_reg, low_reg};
    assign base_row       = base_reg;

endmodule

/* sv/rdsm_cell.sv */
// ----------------------------------------------------------------------------
// rdsm_cell
// One pattern position of the match row: holds its row bit and computes the
// bit for the next text character from its own bit and its left neighbors.
// ----------------------------------------------------------------------------
module rdsm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rdsm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]           text_char,
    input  logic [7:0]           pat_char,
    input  logic [7:0]           prior_char,
    input  logic                 allow_star,
    input  logic                 base_self,
    input  logic                 base_left,
    input  logic                 row_left,
    input  logic                 new_left2,
    output logic                 row_bit,
    output logic                 new_bit
);
    import rdsm_pkg::*;

    logic row_reg;
    logic row_next;
    logic prev_self;
    logic prev_left;
    logic is_star;
    logic p_hit;
    logic q_hit;
    logic step;

    // previous row, either held or the base row
    assign prev_self = ctrl.use_base ? base_self : row_reg;
    assign prev_left = ctrl.use_base ? base_left : row_left;

    // character compares
    assign is_star = (pat_char == CH_STAR);
    assign p_hit   = (pat_char == CH_ANY) | (pat_char == text_char);
    assign q_hit   = (prior_char == CH_ANY) | (prior_char == text_char);

    // star: skip the pair or repeat; leading star matches nothing
    always_comb
    begin
        if (is_star)
        begin
            step = allow_star & (new_left2 | (q_hit & prev_self));
        end
        else
        begin
            step = p_hit & prev_left;
        end
    end

    assign new_bit  = ctrl.has_char ? step : base_self;
    assign row_next = ctrl.advance ? new_bit : row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_bit = row_reg;

endmodule

/* sv/regex_dot_star_matcher_top.sv */
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_top
// Streaming matcher of a text against a pattern of literals, '.' and '*'.
// ----------------------------------------------------------------------------
// Each input item carries one text character and returns one result item
// telling whether the text so far matches the whole configured pattern. A
// row of PATTERN_MAX cells updates every pattern position together, with the
// star skips rippling through the row in the same cycle, and one result
// register sits before the output, so the result is shown in the cycle after
// its item is accepted. A new item is taken every cycle as long as the result
// register is empty or being drained, so the throughput is one item per cycle.
// The tuser bit has_char low presents an empty text; first_char restarts the
// row from the base row. Write the pattern only while no item is in flight.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher_top #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] text_char
    input  logic [1:0]                   s_tuser,   // [0] has_char, [1] first_char
    input  logic                         s_tlast,   // last_char
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [0] prefix_matched, [7:1] zero
    output logic                         m_tlast,   // end_of_string
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdsm_pkg::PADDR_W-1:0] paddr,
    input  logic [rdsm_pkg::PDATA_W-1:0] pwdata,
    output logic [rdsm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import rdsm_pkg::*;

    localparam int              IDX_W = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] PM_LEN = LEN_W'(PATTERN_MAX);

    logic [LEN_W-1:0]       pattern_length;
    logic [8*PAT_CHARS-1:0] pattern_chars;
    logic [PATTERN_MAX:0]   base_row;
    logic [PATTERN_MAX:0]   row_bits;
    logic [PATTERN_MAX:0]   new_row;
    logic [LEN_W-1:0]       len_eff;
    logic                   s_accept;
    cell_ctrl_t             ctrl;
    logic                   row0_reg;
    logic                   row0_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_match_reg;
    logic                   out_match_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    assign pready = 1'b1;

    // configuration registers and base row
    rdsm_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pattern_length (pattern_length),
        .pattern_chars  (pattern_chars),
        .base_row       (base_row)
    );

    // handshake: take an item whenever the result slot frees up
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign ctrl.advance  = s_accept;
    assign ctrl.use_base = s_tuser[1];
    assign ctrl.has_char = s_tuser[0];

    // position zero: set only for the empty text
    assign new_row[0]  = !s_tuser[0];
    assign row_bits[0] = row0_reg;
    assign row0_next   = s_accept ? new_row[0] : row0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= 1'b0;
        end
        else
        begin
            row0_reg <= row0_next;
        end
    end

    // row of cells, one per pattern position
    for (genvar j = 1; j <= PATTERN_MAX; j++)
    begin : g_cell
        logic [7:0] prior_char;
        logic       new_left2;
        logic       allow_star;

        if (j >= 2)
        begin : g_star
            assign prior_char = pattern_chars[8*(j-2) +: 8];
            assign new_left2  = new_row[j-2];
            assign allow_star = 1'b1;
        end
        else
        begin : g_lead
            assign prior_char = 8'h00;
            assign new_left2  = 1'b0;
            assign allow_star = 1'b0;
        end

        rdsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .text_char  (s_tdata),
            .pat_char   (pattern_chars[8*(j-1) +: 8]),
            .prior_char (prior_char),
            .allow_star (allow_star),
            .base_self  (base_row[j]),
            .base_left  (base_row[j-1]),
            .row_left   (row_bits[j-1]),
            .new_left2  (new_left2),
            .row_bit    (row_bits[j]),
            .new_bit    (new_row[j])
        );
    end

    // clamp the pattern length to the number of cells
    assign len_eff = (pattern_length > PM_LEN) ? PM_LEN : pattern_length;

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_match_next = s_accept ? new_row[len_eff[IDX_W-1:0]] : out_match_reg;
    assign out_last_next  = s_accept ? s_tlast : out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // an accepted item always yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid)
        else $error("accepted item produced no result");

    // position zero holds only after an empty text
    a_row0_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (row0_reg == !$past(s_tuser[0])))
        else $error("row position zero out of step with has_char");

    // an empty text gives the base-row verdict
    a_empty_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_tuser[0]) |=>
            (m_tdata[0] == $past(base_row[len_eff[IDX_W-1:0]])))
        else $error("empty text verdict differs from base row");

    // the end marker follows its item
    a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (m_tlast == $past(s_tlast)))
        else $error("end_of_string not copied from last_char");
`endif

endmodule
